### design/cpde_pkg.sv
// ---------------------------------------------------------------------------
// cpde_pkg: shared types and constants for the circle point/derivative block
// Holds the CORDIC widths and arctangent table, the register index codes,
// and the record passed from the CORDIC pipeline to the combine pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package cpde_pkg;

  // CORDIC datapath widths: x/y in signed Q30 with headroom, z in 2^-32 turn.
  localparam int CORD_W    = 34;
  localparam int Z_W       = 33;
  // Folded and clamped cos/sin, range [-2^30, 2^30].
  localparam int TRIG_W    = 32;
  localparam int FRAC_BITS = 30;
  localparam int ORDER_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_AXES  = 3;
  localparam int ATAN_N    = 32;

  localparam logic signed [CORD_W-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CORD_W-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [CORD_W-1:0] Q30_NEG_ONE = -34'sd1073741824;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN32 [ATAN_N] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER  = 3'd0,
    REG_XAXIS_X = 3'd1,
    REG_XAXIS_Y = 3'd2,
    REG_XAXIS_Z = 3'd3,
    REG_YAXIS_X = 3'd4,
    REG_YAXIS_Y = 3'd5,
    REG_YAXIS_Z = 3'd6
  } cfg_reg_t;

  // Quadrant of the angle (top two bits of the turn fraction).
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // Derivative phase, (n-1) mod 4.
  typedef enum logic [1:0] {
    PHASE_0 = 2'd0,
    PHASE_1 = 2'd1,
    PHASE_2 = 2'd2,
    PHASE_3 = 2'd3
  } phase_t;

  // Result of the rotation pipeline, before quadrant folding.
  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    quad_t                    quad;
    logic [ORDER_W-1:0]       order;
  } cord_res_t;

endpackage

`default_nettype wire

### design/cpde_in_if.sv
// ---------------------------------------------------------------------------
// cpde_in_if: input channel of the circle point/derivative block
// One beat carries an angle (fraction of a turn) and a derivative order.
// ---------------------------------------------------------------------------
`default_nettype none

interface cpde_in_if #(
  parameter int ANGLE_BITS = 16
);
  logic                           valid;
  logic                           ready;
  logic [ANGLE_BITS-1:0]          angle;
  logic [cpde_pkg::ORDER_W-1:0]   deriv_order;

  modport source (output valid, output angle, output deriv_order, input ready);
  modport sink   (input valid, input angle, input deriv_order, output ready);
endinterface

`default_nettype wire

### design/cpde_out_if.sv
// ---------------------------------------------------------------------------
// cpde_out_if: result channel of the circle point/derivative block
// One beat carries a saturated point or derivative vector.
// ---------------------------------------------------------------------------
`default_nettype none

interface cpde_out_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

### design/cpde_cfg.sv
// ---------------------------------------------------------------------------
// cpde_cfg: configuration registers
// Holds the packed center and the two radius-scaled axis vectors, and
// unpacks the center into signed coordinates.
// ---------------------------------------------------------------------------
`default_nettype none

module cpde_cfg #(
  parameter int COORD_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cpde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [3*COORD_BITS-1:0]             cfg_data,
  output logic signed [COORD_BITS-1:0]        center [cpde_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0]        xaxis  [cpde_pkg::NUM_AXES],
  output logic signed [COORD_BITS-1:0]        yaxis  [cpde_pkg::NUM_AXES]
);
  import cpde_pkg::*;

  localparam int CFG_W  = 3 * COORD_BITS;
  // Center bits beyond a 64-bit word always read as zero.
  localparam int KEEP_W = (CFG_W > 64) ? 64 : CFG_W;
  localparam logic [CFG_W-1:0] KEEP_MASK = ~({CFG_W{1'b1}} << KEEP_W);

  logic [CFG_W-1:0]             center_r;
  logic signed [COORD_BITS-1:0] xax_r [NUM_AXES];
  logic signed [COORD_BITS-1:0] yax_r [NUM_AXES];

  // Register writes; an index outside the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      for (int k = 0; k < NUM_AXES; k++) begin
        xax_r[k] <= '0;
        yax_r[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER:  center_r <= cfg_data & KEEP_MASK;
        REG_XAXIS_X: xax_r[0] <= cfg_data[COORD_BITS-1:0];
        REG_XAXIS_Y: xax_r[1] <= cfg_data[COORD_BITS-1:0];
        REG_XAXIS_Z: xax_r[2] <= cfg_data[COORD_BITS-1:0];
        REG_YAXIS_X: yax_r[0] <= cfg_data[COORD_BITS-1:0];
        REG_YAXIS_Y: yax_r[1] <= cfg_data[COORD_BITS-1:0];
        REG_YAXIS_Z: yax_r[2] <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the center, x in the lowest bits.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      center[k] = center_r[k*COORD_BITS +: COORD_BITS];
      xaxis[k]  = xax_r[k];
      yaxis[k]  = yax_r[k];
    end
  end

endmodule

`default_nettype wire

### design/cpde_cordic.sv
// ---------------------------------------------------------------------------
// cpde_cordic: pipelined rotation-mode CORDIC
// Stage 0 splits the angle into quadrant and residual and loads the gain;
// each further stage performs one micro-rotation.
// ---------------------------------------------------------------------------
`default_nettype none

module cpde_cordic #(
  parameter int ANGLE_BITS  = 16,
  parameter int TRIG_STAGES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ANGLE_BITS-1:0]           in_angle,
  input  logic [cpde_pkg::ORDER_W-1:0]    in_order,
  output logic                            res_valid,
  input  logic                            res_ready,
  output cpde_pkg::cord_res_t             res
);
  import cpde_pkg::*;

  localparam int NS = TRIG_STAGES + 1;

  logic signed [CORD_W-1:0] x_r   [NS];
  logic signed [CORD_W-1:0] y_r   [NS];
  logic signed [Z_W-1:0]    z_r   [NS];
  quad_t                    quad_r  [NS];
  logic [ORDER_W-1:0]       order_r [NS];
  logic signed [CORD_W-1:0] x_nxt [NS];
  logic signed [CORD_W-1:0] y_nxt [NS];
  logic signed [Z_W-1:0]    z_nxt [NS];
  quad_t                    quad_nxt  [NS];
  logic [ORDER_W-1:0]       order_nxt [NS];
  logic [TRIG_STAGES:0]     v_r;
  logic [TRIG_STAGES:0]     rdy;
  logic [Z_W-1:0]           resid;

  // A stage takes a new beat when it is empty or its contents move on.
  always_comb begin
    rdy[TRIG_STAGES] = !v_r[TRIG_STAGES] || res_ready;
    for (int k = TRIG_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  // Angle decode and the micro-rotations.
  always_comb begin
    resid        = Z_W'(in_angle[ANGLE_BITS-3:0]);
    x_nxt[0]     = GAIN_Q30;
    y_nxt[0]     = '0;
    z_nxt[0]     = resid << (32 - ANGLE_BITS);
    quad_nxt[0]  = quad_t'(in_angle[ANGLE_BITS-1 -: 2]);
    order_nxt[0] = in_order;
    for (int k = 1; k < NS; k++) begin
      if (!z_r[k-1][Z_W-1]) begin
        x_nxt[k] = x_r[k-1] - (y_r[k-1] >>> (k - 1));
        y_nxt[k] = y_r[k-1] + (x_r[k-1] >>> (k - 1));
        z_nxt[k] = z_r[k-1] - Z_W'(ATAN_TURN32[k-1]);
      end else begin
        x_nxt[k] = x_r[k-1] + (y_r[k-1] >>> (k - 1));
        y_nxt[k] = y_r[k-1] - (x_r[k-1] >>> (k - 1));
        z_nxt[k] = z_r[k-1] + Z_W'(ATAN_TURN32[k-1]);
      end
      quad_nxt[k]  = quad_r[k-1];
      order_nxt[k] = order_r[k-1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        x_r[k]     <= x_nxt[k];
        y_r[k]     <= y_nxt[k];
        z_r[k]     <= z_nxt[k];
        quad_r[k]  <= quad_nxt[k];
        order_r[k] <= order_nxt[k];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign res_valid = v_r[TRIG_STAGES];
  assign res.x     = x_r[TRIG_STAGES];
  assign res.y     = y_r[TRIG_STAGES];
  assign res.quad  = quad_r[TRIG_STAGES];
  assign res.order = order_r[TRIG_STAGES];

`ifndef SYNTHESIS
  // Input back-pressure only appears when every rotation stage is occupied.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("cordic pipeline refused a beat while a stage was empty");
`endif

endmodule

`default_nettype wire

### design/cpde_comb.sv
// ---------------------------------------------------------------------------
// cpde_comb: quadrant fold, coefficient select, axis products and output
// Four stages: fold/select, multiply, sum/round, center add/saturate. The
// last stage is the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module cpde_comb #(
  parameter int COORD_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cin_valid,
  output logic                          cin_ready,
  input  cpde_pkg::cord_res_t           cin,
  input  logic signed [COORD_BITS-1:0]  center [cpde_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0]  xaxis  [cpde_pkg::NUM_AXES],
  input  logic signed [COORD_BITS-1:0]  yaxis  [cpde_pkg::NUM_AXES],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS-1:0]  out_vec [cpde_pkg::NUM_AXES]
);
  import cpde_pkg::*;

  localparam int PROD_W = TRIG_W + COORD_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int V_W    = SUM_W - FRAC_BITS;
  localparam int T_W    = V_W + 1;
  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [T_W-1:0]   SAT_HI   =
    T_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [T_W-1:0]   SAT_LO   = -SAT_HI - T_W'(1);
  localparam logic signed [V_W-1:0]   V_MAX    = V_W'(64'sd1 <<< COORD_BITS);
  localparam logic signed [TRIG_W-1:0] T_ONE   = TRIG_W'(Q30_ONE);

  logic [3:0] sv_r;
  logic [3:0] srdy;

  // Fold / select stage.
  logic signed [CORD_W-1:0] c_raw, s_raw, c_cl, s_cl;
  logic signed [TRIG_W-1:0] c_t, s_t;
  logic signed [TRIG_W-1:0] a_nxt, b_nxt, a_r, b_r;
  logic [ORDER_W-1:0]       ord_m1;
  logic                     pt1_r;
  // Multiply stage.
  logic signed [PROD_W-1:0] pa_r [NUM_AXES];
  logic signed [PROD_W-1:0] pb_r [NUM_AXES];
  logic                     pt2_r;
  // Sum / round stage.
  logic signed [SUM_W-1:0]  sum_nxt [NUM_AXES];
  logic signed [V_W-1:0]    val_r   [NUM_AXES];
  logic                     pt3_r;
  // Center add / saturate stage.
  logic signed [T_W-1:0]        tot_nxt [NUM_AXES];
  logic signed [COORD_BITS-1:0] sat_nxt [NUM_AXES];
  logic signed [COORD_BITS-1:0] o_r     [NUM_AXES];

  // Ready chain from the output register back to the CORDIC.
  always_comb begin
    srdy[3] = !sv_r[3] || out_ready;
    for (int k = 2; k >= 0; k--) begin
      srdy[k] = !sv_r[k] || srdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else begin
      if (srdy[0]) sv_r[0] <= cin_valid;
      if (srdy[1]) sv_r[1] <= sv_r[0];
      if (srdy[2]) sv_r[2] <= sv_r[1];
      if (srdy[3]) sv_r[3] <= sv_r[2];
    end
  end

  // Quadrant fold, clamp to one, then pick the coefficient pair.
  always_comb begin
    unique case (cin.quad)
      QUAD_0: begin c_raw = cin.x;  s_raw = cin.y;  end
      QUAD_1: begin c_raw = -cin.y; s_raw = cin.x;  end
      QUAD_2: begin c_raw = -cin.x; s_raw = -cin.y; end
      QUAD_3: begin c_raw = cin.y;  s_raw = -cin.x; end
      default: begin c_raw = cin.x; s_raw = cin.y;  end
    endcase
    if (c_raw > Q30_ONE)          c_cl = Q30_ONE;
    else if (c_raw < Q30_NEG_ONE) c_cl = Q30_NEG_ONE;
    else                          c_cl = c_raw;
    if (s_raw > Q30_ONE)          s_cl = Q30_ONE;
    else if (s_raw < Q30_NEG_ONE) s_cl = Q30_NEG_ONE;
    else                          s_cl = s_raw;
    c_t    = TRIG_W'(c_cl);
    s_t    = TRIG_W'(s_cl);
    ord_m1 = cin.order - ORDER_W'(1);
    if (cin.order == '0) begin
      a_nxt = c_t;
      b_nxt = s_t;
    end else begin
      unique case (phase_t'(ord_m1[1:0]))
        PHASE_0: begin a_nxt = -s_t; b_nxt = c_t;  end
        PHASE_1: begin a_nxt = -c_t; b_nxt = -s_t; end
        PHASE_2: begin a_nxt = s_t;  b_nxt = -c_t; end
        PHASE_3: begin a_nxt = c_t;  b_nxt = s_t;  end
        default: begin a_nxt = c_t;  b_nxt = s_t;  end
      endcase
    end
  end

  // Sum of products, rounded half up to the coordinate scale.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      sum_nxt[k] = SUM_W'(pa_r[k]) + SUM_W'(pb_r[k]) + HALF_LSB;
    end
  end

  // Add the center for a point, then saturate.
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      tot_nxt[k] = T_W'(val_r[k]) + (pt3_r ? T_W'(center[k]) : T_W'(0));
      if (tot_nxt[k] > SAT_HI)      sat_nxt[k] = COORD_BITS'(SAT_HI);
      else if (tot_nxt[k] < SAT_LO) sat_nxt[k] = COORD_BITS'(SAT_LO);
      else                          sat_nxt[k] = COORD_BITS'(tot_nxt[k]);
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (srdy[0]) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      pt1_r <= (cin.order == '0);
    end
    if (srdy[1]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pa_r[k] <= PROD_W'(a_r) * PROD_W'(xaxis[k]);
        pb_r[k] <= PROD_W'(b_r) * PROD_W'(yaxis[k]);
      end
      pt2_r <= pt1_r;
    end
    if (srdy[2]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        val_r[k] <= V_W'(sum_nxt[k] >>> FRAC_BITS);
      end
      pt3_r <= pt2_r;
    end
    if (srdy[3]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        o_r[k] <= sat_nxt[k];
      end
    end
  end

  assign cin_ready = srdy[0];
  assign out_valid = sv_r[3];
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      out_vec[k] = o_r[k];
    end
  end

`ifndef SYNTHESIS
  // Folded coefficients never exceed one in magnitude.
  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[0] |-> (a_r <= T_ONE && a_r >= -T_ONE && b_r <= T_ONE && b_r >= -T_ONE))
    else $error("coefficient outside unit range");
  // Rounded sums stay within twice the coordinate range before the center add.
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[2] |-> (val_r[0] <= V_MAX && val_r[0] >= -V_MAX &&
                 val_r[1] <= V_MAX && val_r[1] >= -V_MAX &&
                 val_r[2] <= V_MAX && val_r[2] >= -V_MAX))
    else $error("rounded product sum out of range");
  // A beat offered to the output stage while it is free is taken at once.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r[2] && !sv_r[3]) |=> sv_r[3])
    else $error("output register failed to load a waiting beat");
`endif

endmodule

`default_nettype wire

### design/circle_point_derivative_eval.sv
// ---------------------------------------------------------------------------
// circle_point_derivative_eval: point or n-th derivative of a circle
// Evaluates C + cos*RX + sin*RY, or the n-th derivative, for one angle per
// beat, with a pipelined CORDIC and saturated fixed-point outputs.
// ---------------------------------------------------------------------------
//
//   channel  | direction | payload                         | handshake
//   ---------+-----------+---------------------------------+--------------
//   in_ch    | sink      | angle, deriv_order              | valid/ready
//   out_ch   | source    | out_x, out_y, out_z             | valid/ready
//   cfg_*    | write     | cfg_index, cfg_data             | cfg_we
//
// Throughput is one beat per cycle unless out_ch stalls; there is one
// decode stage, TRIG_STAGES rotation stages and four combine stages.
// Reset clears all valid bits and the configuration registers; stage
// payload registers are not reset and only matter under a valid bit.
// Each stage holds its beat under back-pressure and keeps accepting while
// any stage behind the output register is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module circle_point_derivative_eval #(
  parameter int ANGLE_BITS  = 16,
  parameter int COORD_BITS  = 20,
  parameter int TRIG_STAGES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cpde_in_if.sink                          in_ch,
  cpde_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [cpde_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [3*COORD_BITS-1:0]          cfg_data
);
  import cpde_pkg::*;

  logic signed [COORD_BITS-1:0] center [NUM_AXES];
  logic signed [COORD_BITS-1:0] xaxis  [NUM_AXES];
  logic signed [COORD_BITS-1:0] yaxis  [NUM_AXES];
  logic signed [COORD_BITS-1:0] res_vec [NUM_AXES];
  cord_res_t                    cord;
  logic                         cord_valid;
  logic                         cord_ready;
  logic                         in_rdy;
  logic                         res_valid;

  // Configuration registers.
  cpde_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .center    (center),
    .xaxis     (xaxis),
    .yaxis     (yaxis)
  );

  // Rotation pipeline.
  cpde_cordic #(
    .ANGLE_BITS  (ANGLE_BITS),
    .TRIG_STAGES (TRIG_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_rdy),
    .in_angle  (in_ch.angle),
    .in_order  (in_ch.deriv_order),
    .res_valid (cord_valid),
    .res_ready (cord_ready),
    .res       (cord)
  );

  // Fold, multiply, round and saturate.
  cpde_comb #(
    .COORD_BITS (COORD_BITS)
  ) u_comb (
    .clk       (clk),
    .rst_n     (rst_n),
    .cin_valid (cord_valid),
    .cin_ready (cord_ready),
    .cin       (cord),
    .center    (center),
    .xaxis     (xaxis),
    .yaxis     (yaxis),
    .out_valid (res_valid),
    .out_ready (out_ch.ready),
    .out_vec   (res_vec)
  );

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = res_valid;
  assign out_ch.out_x = res_vec[0];
  assign out_ch.out_y = res_vec[1];
  assign out_ch.out_z = res_vec[2];

endmodule

`default_nettype wire
